// ----- hw/rtl/rrva_pkg.sv -----
// Shared types and constants for the round-robin voice allocator.
// No dependencies; imported by rrva_freq_store and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rrva_pkg;

  localparam int FREQ_W    = 32;
  localparam int CFG_W     = 5;
  localparam int OUT_IDX_W = 4;

  typedef enum logic {
    OP_NOTE_ON  = 1'b0,
    OP_NOTE_OFF = 1'b1
  } op_t;

  typedef struct packed {
    logic              en;
    logic [FREQ_W-1:0] data;
  } mem_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/round_robin_voice_allocator_top.sv -----
// Round-robin voice allocator: top level with sequencer, gate flags and output register.
// Depends on rrva_pkg and rrva_freq_store.
//
// Usage: note events arrive on the in_ stream (tuser bit 0 = 0 for note on, 1 for note
// off; tdata = frequency word). Each event gives exactly one transfer on the out_ stream.
// A note on writes the voice under the round-robin pointer and advances the pointer,
// wrapping at voices_used clamped to 1..MAX_VOICES. A note off searches from the most
// recently allocated voice backwards and clears the gate of the first voice whose stored
// word equals the key. Timing: a note on loads the result register at the input transfer
// and moves it from ST_EMIT into the output register once that register is free. A note
// off reads one stored word per cycle through the single read port of the frequency store,
// up to and including the match or through every voice in use on a miss, then moves its
// result the same way. in_tready is high only while the sequencer is idle, one event at a
// time, and rises in the same cycle as the result is loaded into the output register.
// The output register holds a finished result while the receiver stalls; the next
// event is already taken meanwhile, and a new result waits until the register frees.
// Reset (rst_n low, synchronous) clears all gates and the pointer, makes stored frequency words
// read as zero, sets voices_used to 16 and empties the output register. cfg_wr_en writes
// voices_used and must only be used while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_voice_allocator_top
  import rrva_pkg::*;
#(
  parameter int MAX_VOICES = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // Configuration
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,  // voices_used
  // Input stream
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [31:0]      in_tdata,     // [31:0] freq_bits
  input  wire logic [0:0]       in_tuser,     // [0] operation
  // Output stream
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [39:0]      out_tdata,    // [3:0] voice_index, [4] gate_out,
                                              // [36:5] freq_out, [39:37] zero
  output logic      [0:0]       out_tuser     // [0] hit
);

  localparam int AW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CW = $clog2(MAX_VOICES + 1);
  localparam int MW = (CW > CFG_W) ? CW : CFG_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CFG_W-1:0]       voices_used_r, voices_used_nxt;
  logic [AW-1:0]          next_voice_r, next_voice_nxt;
  logic [MAX_VOICES-1:0]  gate_r, gate_nxt;
  logic [CW-1:0]          n_r, n_nxt;
  logic [FREQ_W-1:0]      key_r, key_nxt;
  logic [AW-1:0]          rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]          issued_r, issued_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]          res_idx_r, res_idx_nxt;
  logic                   res_gate_r, res_gate_nxt;
  logic [FREQ_W-1:0]      res_freq_r, res_freq_nxt;
  logic                   res_hit_r, res_hit_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [AW-1:0]          out_idx_r, out_idx_nxt;
  logic                   out_gate_r, out_gate_nxt;
  logic [FREQ_W-1:0]      out_freq_r, out_freq_nxt;
  logic                   out_hit_r, out_hit_nxt;

  logic [CW-1:0]          n_eff;
  logic [AW-1:0]          slot;
  logic                   in_fire;
  op_t                    in_op;
  logic                   match;
  mem_wr_t                mem_wr;
  logic                   rd_en;
  logic [FREQ_W-1:0]      rd_data;

  rrva_freq_store #(
    .DEPTH (MAX_VOICES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (mem_wr),
    .wr_addr (slot),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  always_comb begin
    if (voices_used_r == '0) begin
      n_eff = CW'(1);
    end else if (MW'(voices_used_r) > MW'(MAX_VOICES)) begin
      n_eff = CW'(MAX_VOICES);
    end else begin
      n_eff = CW'(voices_used_r);
    end
    slot = (CW'(next_voice_r) < n_eff) ? next_voice_r : '0;
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_op     = op_t'(in_tuser[0]);
  assign match     = cmp_vld_r && (rd_data == key_r);
  assign rd_en     = (state_r == ST_SCAN) && (issued_r < n_r);

  always_comb begin
    mem_wr.en   = in_fire && (in_op == OP_NOTE_ON);
    mem_wr.data = in_tdata;
  end

  always_comb begin
    state_nxt       = state_r;
    voices_used_nxt = cfg_wr_en ? cfg_wr_data : voices_used_r;
    next_voice_nxt  = next_voice_r;
    gate_nxt        = gate_r;
    n_nxt           = n_r;
    key_nxt         = key_r;
    rd_addr_nxt     = rd_addr_r;
    issued_nxt      = issued_r;
    cmp_vld_nxt     = 1'b0;
    cmp_idx_nxt     = cmp_idx_r;
    res_idx_nxt     = res_idx_r;
    res_gate_nxt    = res_gate_r;
    res_freq_nxt    = res_freq_r;
    res_hit_nxt     = res_hit_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_idx_nxt     = out_idx_r;
    out_gate_nxt    = out_gate_r;
    out_freq_nxt    = out_freq_r;
    out_hit_nxt     = out_hit_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          n_nxt   = n_eff;
          key_nxt = in_tdata;
          if (in_op == OP_NOTE_ON) begin
            gate_nxt[slot] = 1'b1;
            next_voice_nxt = ((CW'(slot) + CW'(1)) >= n_eff) ? '0 : slot + AW'(1);
            res_idx_nxt    = slot;
            res_gate_nxt   = 1'b1;
            res_freq_nxt   = in_tdata;
            res_hit_nxt    = 1'b1;
            state_nxt      = ST_EMIT;
          end else begin
            rd_addr_nxt = (slot == '0) ? AW'(n_eff - CW'(1)) : slot - AW'(1);
            issued_nxt  = '0;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          issued_nxt  = issued_r + CW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_addr_r;
          rd_addr_nxt = (rd_addr_r == '0) ? AW'(n_r - CW'(1)) : rd_addr_r - AW'(1);
        end
        if (match) begin
          gate_nxt[cmp_idx_r] = 1'b0;
          res_idx_nxt  = cmp_idx_r;
          res_gate_nxt = 1'b0;
          res_freq_nxt = rd_data;
          res_hit_nxt  = 1'b1;
          cmp_vld_nxt  = 1'b0;
          state_nxt    = ST_EMIT;
        end else if (cmp_vld_r && (issued_r == n_r)) begin
          res_idx_nxt  = '0;
          res_gate_nxt = 1'b0;
          res_freq_nxt = '0;
          res_hit_nxt  = 1'b0;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_gate_nxt  = res_gate_r;
          out_freq_nxt  = res_freq_r;
          out_hit_nxt   = res_hit_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      voices_used_r <= CFG_W'(16);
      next_voice_r  <= '0;
      gate_r        <= '0;
      issued_r      <= '0;
      cmp_vld_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      voices_used_r <= voices_used_nxt;
      next_voice_r  <= next_voice_nxt;
      gate_r        <= gate_nxt;
      issued_r      <= issued_nxt;
      cmp_vld_r     <= cmp_vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    key_r      <= key_nxt;
    rd_addr_r  <= rd_addr_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    res_idx_r  <= res_idx_nxt;
    res_gate_r <= res_gate_nxt;
    res_freq_r <= res_freq_nxt;
    res_hit_r  <= res_hit_nxt;
    out_idx_r  <= out_idx_nxt;
    out_gate_r <= out_gate_nxt;
    out_freq_r <= out_freq_nxt;
    out_hit_r  <= out_hit_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_freq_r, out_gate_r, OUT_IDX_W'(out_idx_r)};
  assign out_tuser  = out_hit_r;

  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("unmatched note off carries a non-zero payload");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> issued_r <= n_r)
    else $error("search read more voices than are in rotation");

  a_pointer_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_op == OP_NOTE_ON |=> CW'(next_voice_r) < n_r)
    else $error("round-robin pointer left the rotation");

  a_note_on_gate: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_op == OP_NOTE_ON |=> gate_r[res_idx_r] && res_hit_r)
    else $error("note on did not raise the gate of its voice");

  a_match_clears_gate: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && match |=> !gate_r[res_idx_r] && state_r == ST_EMIT)
    else $error("matched note off left the gate set");

endmodule

`default_nettype wire

// ----- hw/rtl/rrva_freq_store.sv -----
// Frequency word store: one write port, one read port with registered data.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses rrva_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrva_freq_store
  import rrva_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mem_wr_t           wr,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [FREQ_W-1:0] rd_data
);

  logic [FREQ_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [FREQ_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- tb/sv/round_robin_voice_allocator_top_tb.sv -----
// Self-checking testbench for round_robin_voice_allocator_top: directed and random note events
// with random stalls on both streams, checked against an in-bench allocator model.
// Depends on rrva_pkg and the allocator RTL.
`timescale 1ns / 1ps

module round_robin_voice_allocator_top_tb;
  import rrva_pkg::*;

  localparam int VOICE_SLOTS = 16;
  localparam int PHASE_NOTES = 175;

  typedef struct packed {
    op_t               op;
    logic [FREQ_W-1:0] key;
  } note_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] voice;
    logic                 gate;
    logic [FREQ_W-1:0]    freq;
    logic                 hit;
  } voice_event_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]     cfg_wr_data = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata = '0;
  logic [0:0]           in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;
  logic [0:0]           out_tuser;

  // Allocator model state.
  logic                 gate_model [VOICE_SLOTS];
  logic [FREQ_W-1:0]    freq_model [VOICE_SLOTS];
  int                   rr_ptr;
  logic [CFG_W-1:0]     voice_count_model;

  note_t                pending_notes [$];
  voice_event_t         expected_events [$];
  note_t                note_in_flight;
  logic [FREQ_W-1:0]    key_pool [8];
  bit                   steady = 1'b0;

  int                   error_count = 0;
  int                   notes_on = 0;
  int                   offs_matched = 0;
  int                   offs_missed = 0;
  int                   stale_ptr_uses = 0;
  int                   settings_used = 0;
  int                   results_seen = 0;

  round_robin_voice_allocator_top #(
    .MAX_VOICES(VOICE_SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report(string msg);
    error_count++;
    if (error_count <= 20) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
  endtask

  // Applies one note event to the model and returns the result it should produce.
  function automatic voice_event_t apply_note(note_t n);
    voice_event_t r;
    int count;
    int slot;
    int i;
    int j;
    bit found;
    r = '0;
    found = 1'b0;
    if (voice_count_model == 0) begin
      count = 1;
    end else if (voice_count_model > VOICE_SLOTS) begin
      count = VOICE_SLOTS;
    end else begin
      count = voice_count_model;
    end
    if (rr_ptr >= count) begin
      stale_ptr_uses++;
    end
    slot = (rr_ptr < count) ? rr_ptr : 0;
    if (n.op == OP_NOTE_ON) begin
      gate_model[slot] = 1'b1;
      freq_model[slot] = n.key;
      rr_ptr = (slot + 1 >= count) ? 0 : slot + 1;
      r.voice = slot[OUT_IDX_W-1:0];
      r.gate = 1'b1;
      r.freq = n.key;
      r.hit = 1'b1;
      notes_on++;
    end else begin
      for (i = 1; i <= count && !found; i++) begin
        j = (count + slot - i) % count;
        if (freq_model[j] == n.key) begin
          found = 1'b1;
          gate_model[j] = 1'b0;
          r.voice = j[OUT_IDX_W-1:0];
          r.freq = freq_model[j];
          r.hit = 1'b1;
        end
      end
      if (found) begin
        offs_matched++;
      end else begin
        offs_missed++;
      end
    end
    return r;
  endfunction

  task automatic check_result(logic [39:0] data, logic hit);
    voice_event_t want;
    results_seen++;
    if (expected_events.size() == 0) begin
      report($sformatf("result transfer with nothing expected (data %h)", data));
    end else begin
      want = expected_events.pop_front();
      if (data[3:0] !== want.voice) begin
        report($sformatf("voice_index %0d, expected %0d", data[3:0], want.voice));
      end
      if (data[4] !== want.gate) begin
        report($sformatf("gate_out %b, expected %b", data[4], want.gate));
      end
      if (data[36:5] !== want.freq) begin
        report($sformatf("freq_out %h, expected %h", data[36:5], want.freq));
      end
      if (hit !== want.hit) begin
        report($sformatf("hit %b, expected %b", hit, want.hit));
      end
    end
  endtask

  // Input driver: a transfer updates the model, then the next pending note is offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_events.push_back(apply_note(note_in_flight));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_notes.size() != 0 && (steady || $urandom_range(0, 99) >= 7)) begin
          note_in_flight = pending_notes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= note_in_flight.key;
          in_tuser <= note_in_flight.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_result(out_tdata, out_tuser[0]);
      end
      out_tready <= steady || ($urandom_range(0, 99) >= 7);
    end
  end

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_notes.size() != 0 || in_tvalid || expected_events.size() != 0);
  endtask

  task automatic write_voice_count(logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    voice_count_model = value;
    settings_used++;
    @(negedge clk);
  endtask

  function automatic void refresh_key_pool();
    logic [FREQ_W-1:0] specials [4];
    int k;
    specials = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FC0_0000};
    for (k = 0; k < 8; k++) begin
      key_pool[k] = ($urandom_range(0, 3) == 0) ? specials[$urandom_range(0, 3)] : $urandom;
    end
  endfunction

  // Mostly keys from a small pool so that note offs find duplicates and matches.
  function automatic note_t random_note();
    note_t n;
    int roll;
    n.op = ($urandom_range(0, 99) < 58) ? OP_NOTE_ON : OP_NOTE_OFF;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      n.key = key_pool[$urandom_range(0, 7)];
    end else if (roll < 80 && n.op == OP_NOTE_OFF) begin
      n.key = freq_model[$urandom_range(0, VOICE_SLOTS - 1)];
    end else begin
      n.key = $urandom;
    end
    return n;
  endfunction

  task automatic push_note(op_t op, logic [FREQ_W-1:0] key);
    note_t n;
    n.op = op;
    n.key = key;
    pending_notes.push_back(n);
  endtask

  initial begin
    logic [CFG_W-1:0] voice_counts [11];
    int p;
    int k;
    voice_counts = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd16, 5'd2, 5'd12, 5'd16, 5'd3, 5'd9};
    for (k = 0; k < VOICE_SLOTS; k++) begin
      gate_model[k] = 1'b0;
      freq_model[k] = '0;
    end
    rr_ptr = 0;
    voice_count_model = 5'd16;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values first, then signed zeros, NaN keys, duplicates and a miss.
    write_voice_count(5'd16);
    push_note(OP_NOTE_OFF, 32'h0000_0000);
    push_note(OP_NOTE_ON,  32'h0000_0000);
    push_note(OP_NOTE_ON,  32'hFFFF_FFFF);
    push_note(OP_NOTE_ON,  32'h7FC0_0000);
    push_note(OP_NOTE_ON,  32'h8000_0000);
    push_note(OP_NOTE_ON,  32'h7FC0_0000);
    push_note(OP_NOTE_OFF, 32'h7FC0_0000);
    push_note(OP_NOTE_OFF, 32'h7FC0_0000);
    push_note(OP_NOTE_OFF, 32'h8000_0000);
    push_note(OP_NOTE_OFF, 32'h0000_0000);
    push_note(OP_NOTE_OFF, 32'h1234_5678);
    push_note(OP_NOTE_OFF, 32'hFFFF_FFFF);
    push_note(OP_NOTE_ON,  32'h0000_0001);
    push_note(OP_NOTE_ON,  32'hFFFF_FFFE);
    push_note(OP_NOTE_OFF, 32'hFFFF_FFFF);
    push_note(OP_NOTE_OFF, 32'h0000_0001);
    wait_drained();

    // Each phase sets a new voice count while idle; lowering it may strand the pointer.
    for (p = 0; p < 11; p++) begin
      write_voice_count(voice_counts[p]);
      steady = (p == 5);
      refresh_key_pool();
      for (k = 0; k < PHASE_NOTES; k++) begin
        pending_notes.push_back(random_note());
      end
      wait_drained();
    end
    steady = 1'b0;

    repeat (40) @(posedge clk);
    $display("Covered %0d note ons, %0d matched and %0d unmatched note offs, %0d results,",
             notes_on, offs_matched, offs_missed, results_seen);
    $display("over %0d voice-count settings, with the pointer out of rotation %0d times.",
             settings_used, stale_ptr_uses);
    if (error_count == 0) begin
      $display("round_robin_voice_allocator_top_tb: clean");
    end else begin
      $display("round_robin_voice_allocator_top_tb: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d notes pending and %0d results outstanding.",
             pending_notes.size(), expected_events.size());
    $display("round_robin_voice_allocator_top_tb: errors");
    $finish;
  end

endmodule

// ----- round_robin_voice_allocator_top.f -----
hw/rtl/rrva_pkg.sv
hw/rtl/rrva_freq_store.sv
hw/rtl/round_robin_voice_allocator_top.sv
tb/sv/round_robin_voice_allocator_top_tb.sv
